// File: design/crf_pkg.sv
// crf_pkg: sizes, payload types, command/status codes and pointer helpers
// for the circular ring FIFO. No dependencies; every other design file imports it.
`default_nettype none

package crf_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef logic [PTR_W-1:0]            ptr_t;
  typedef logic [CNT_W-1:0]            cnt_t;
  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_DUMP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } crf_state_t;

  // Step a slot index, wrapping at the active capacity.
  function automatic ptr_t ptr_advance(ptr_t idx, cnt_t cap);
    cnt_t nxt;
    nxt = CNT_W'(idx) + CNT_W'(1);
    return (nxt >= cap) ? '0 : PTR_W'(nxt);
  endfunction

  // Fold a written capacity into the range 1..DEPTH.
  function automatic cnt_t cap_clamp(cnt_t v);
    if (v == '0) return CNT_W'(1);
    if (v > CNT_W'(DEPTH)) return CNT_W'(DEPTH);
    return v;
  endfunction

endpackage

`default_nettype wire

// File: design/crf_if.sv
// crf_if: valid/ready channel interfaces for the ring FIFO (command in,
// result out, capacity write). Depends on crf_pkg for widths.
`default_nettype none

interface crf_in_if import crf_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  [1:0] command;
  word_t value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface crf_out_if import crf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  word_t      data;
  cnt_t       count;
  logic       last;

  modport source (output valid, output status, output data, output count, output last,
                  input ready);
  modport sink   (input valid, input status, input data, input count, input last,
                  output ready);
endinterface

interface crf_cfg_if import crf_pkg::*; ();
  logic valid;
  logic ready;
  cnt_t capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

// File: design/circular_ring_fifo_core.sv
// circular_ring_fifo_core: ring-buffer FIFO with enqueue, dequeue, peek and dump.
// Depends on crf_pkg and the channel interfaces in crf_if.sv.
//
//   channel | dir | payload                          | transaction when
//   --------+-----+----------------------------------+------------------------
//   in_if   | in  | command, value                   | valid && ready
//   out_if  | out | status, data, count, last        | valid && ready
//   cfg_if  | in  | capacity                         | valid && ready
//
// Flow: one command is taken, then its results leave one per cycle from the
// output register while out_if.ready is high; enqueue, dequeue and peek give one
// result, dump one per held word, read through the single read port of the slot memory.
// Reset: synchronous, active low; queue empty, capacity DEPTH. Slots are not
// cleared, so there is no sweep after reset.
// Stalls: out_if.ready low holds the output register and the pending result;
// a new command is taken while the last result of the previous one waits.
`default_nettype none

module circular_ring_fifo_core import crf_pkg::*; (
  input  wire          clk,
  input  wire          rst_n,
  crf_in_if.sink       in_if,
  crf_out_if.source    out_if,
  crf_cfg_if.sink      cfg_if
);

  // Slot memory: one write port (tail), one registered read port.
  word_t      slots_mem [DEPTH];
  word_t      rd_data_r;
  ptr_t       rd_addr;
  logic       mem_we;

  crf_state_t state_r, state_nxt;
  cnt_t       cap_r, cap_nxt;
  ptr_t       head_r, head_nxt;
  ptr_t       tail_r, tail_nxt;
  cnt_t       count_r, count_nxt;

  // Pending result of the command in progress.
  ptr_t       cur_r, cur_nxt;
  cnt_t       rem_r, rem_nxt;
  status_t    res_status_r, res_status_nxt;
  logic       use_mem_r, use_mem_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  status_t    out_status_r;
  word_t      out_data_r;
  cnt_t       out_count_r;
  logic       out_last_r;

  logic       in_fire, cfg_fire, out_free, send_fire;
  logic       is_full, is_empty;
  cmd_t       cmd;

  assign in_fire   = in_if.valid && in_if.ready;
  assign cfg_fire  = cfg_if.valid && cfg_if.ready;
  assign out_free  = !out_valid_r || out_if.ready;
  assign send_fire = (state_r == ST_SEND) && out_free;
  assign is_full   = (count_r >= cap_r);
  assign is_empty  = (count_r == '0);
  assign cmd       = cmd_t'(in_if.command);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (send_fire && rem_r == CNT_W'(1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_if.ready  = (state_r == ST_IDLE);
    cfg_if.ready = 1'b1;
    out_if.valid  = out_valid_r;
    out_if.status = out_status_r;
    out_if.data   = out_data_r;
    out_if.count  = out_count_r;
    out_if.last   = out_last_r;
  end

  // Queue pointers and the pending result.
  always_comb begin
    cap_nxt        = cap_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    rem_nxt        = rem_r;
    res_status_nxt = res_status_r;
    use_mem_nxt    = use_mem_r;
    mem_we         = 1'b0;

    if (in_fire) begin
      cur_nxt        = head_r;
      rem_nxt        = CNT_W'(1);
      res_status_nxt = STAT_OK;
      use_mem_nxt    = 1'b0;
      case (cmd)
        CMD_ENQ: begin
          if (is_full) begin
            res_status_nxt = STAT_FULL;  // drop the word, state unchanged
          end else begin
            mem_we    = 1'b1;
            tail_nxt  = ptr_advance(tail_r, cap_r);
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_DEQ: begin
          if (is_empty) begin
            res_status_nxt = STAT_EMPTY;
          end else begin
            use_mem_nxt = 1'b1;
            count_nxt   = count_r - CNT_W'(1);
            if (count_r == CNT_W'(1)) begin
              // Queue drains: both pointers go back to slot zero.
              head_nxt = '0;
              tail_nxt = '0;
            end else begin
              head_nxt = ptr_advance(head_r, cap_r);
            end
          end
        end
        CMD_PEEK: begin
          if (is_empty) res_status_nxt = STAT_EMPTY;
          else          use_mem_nxt    = 1'b1;
        end
        CMD_DUMP: begin
          if (is_empty) begin
            res_status_nxt = STAT_EMPTY;
          end else begin
            use_mem_nxt = 1'b1;
            rem_nxt     = count_r;
          end
        end
        default: res_status_nxt = STAT_OK;
      endcase
    end else if (send_fire && rem_r > CNT_W'(1)) begin
      // Dump: step to the next held word; its read lands by the next cycle.
      cur_nxt = ptr_advance(cur_r, cap_r);
      rem_nxt = rem_r - CNT_W'(1);
    end

    if (cfg_fire) begin
      cap_nxt   = cap_clamp(cfg_if.capacity);
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end
  end

  // Read the slot that the pending result will need in the next cycle.
  assign rd_addr = cur_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (send_fire)          out_valid_nxt = 1'b1;
    else if (out_if.ready)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) slots_mem[tail_r] <= in_if.value;
    rd_data_r <= slots_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CNT_W'(DEPTH);
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    res_status_r <= res_status_nxt;
    use_mem_r    <= use_mem_nxt;
    if (send_fire) begin
      out_status_r <= res_status_r;
      out_data_r   <= use_mem_r ? rd_data_r : '0;
      out_count_r  <= count_r;
      out_last_r   <= (rem_r == CNT_W'(1));
    end
  end

  // Checks on the queue bookkeeping and sequencing.
  a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("held count exceeds capacity");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == '0 && tail_r == '0))
    else $error("empty queue with pointers off slot zero");

  a_accept_send: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_SEND))
    else $error("accepted command did not start sending");

  a_send_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEND) |-> (rem_r != '0))
    else $error("sending with no results left");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (send_fire && rem_r == CNT_W'(1)) |=> (state_r == ST_IDLE && out_valid_r && out_last_r))
    else $error("final result not marked or not idle after");

endmodule

`default_nettype wire

// File: sim/circular_ring_fifo_core_checker.sv
`timescale 1ns / 100ps
// Checker for circular_ring_fifo_core: watches the command, result and capacity
// channels, keeps its own copy of the ring FIFO and compares every result.
// Depends on crf_pkg and the channel interfaces in crf_if.sv.

module circular_ring_fifo_core_checker import crf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  crf_in_if           in_ch,
  crf_out_if          out_ch,
  crf_cfg_if          cfg_ch,
  output int unsigned mismatches,
  output int unsigned results_due
);

  typedef struct {
    status_t status;
    word_t   data;
    cnt_t    count;
    logic    last;
  } fifo_result_t;

  fifo_result_t due_q[$];
  word_t        slot_mem [DEPTH];
  ptr_t         head_ptr;
  ptr_t         tail_ptr;
  cnt_t         held;
  cnt_t         cap_reg;

  initial begin
    mismatches  = 0;
    results_due = 0;
  end

  // Zero means one slot, anything above the storage depth means all of it.
  function automatic int usable_slots(cnt_t raw);
    if (raw == '0) return 1;
    if (int'(raw) > DEPTH) return DEPTH;
    return int'(raw);
  endfunction

  function automatic ptr_t wrap_step(ptr_t idx);
    int nxt;
    nxt = int'(idx) + 1;
    return (nxt >= usable_slots(cap_reg)) ? '0 : ptr_t'(nxt);
  endfunction

  task automatic push_result(status_t st, word_t d, logic lst);
    fifo_result_t r;
    r.status = st;
    r.data   = d;
    r.count  = held;
    r.last   = lst;
    due_q.push_back(r);
  endtask

  task automatic drop_all();
    head_ptr = '0;
    tail_ptr = '0;
    held     = '0;
  endtask

  task automatic run_command(cmd_t op, word_t v);
    ptr_t  idx;
    word_t w;
    if (op == CMD_ENQ) begin
      if (int'(held) >= usable_slots(cap_reg)) begin
        push_result(STAT_FULL, '0, 1'b1);
      end else begin
        slot_mem[tail_ptr] = v;
        tail_ptr = wrap_step(tail_ptr);
        held = held + CNT_W'(1);
        push_result(STAT_OK, '0, 1'b1);
      end
    end else if (held == '0) begin
      push_result(STAT_EMPTY, '0, 1'b1);
    end else if (op == CMD_DEQ) begin
      w = slot_mem[head_ptr];
      held = held - CNT_W'(1);
      // both pointers go back to slot zero once the queue runs dry
      if (held == '0) drop_all();
      else head_ptr = wrap_step(head_ptr);
      push_result(STAT_OK, w, 1'b1);
    end else if (op == CMD_PEEK) begin
      push_result(STAT_OK, slot_mem[head_ptr], 1'b1);
    end else begin
      idx = head_ptr;
      for (int k = 0; k < int'(held); k++) begin
        push_result(STAT_OK, slot_mem[idx], (k + 1) == int'(held));
        idx = wrap_step(idx);
      end
    end
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    fifo_result_t r;
    if (!rst_n) begin
      due_q.delete();
      drop_all();
      cap_reg = CNT_W'(DEPTH);
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        cap_reg = cfg_ch.capacity;
        drop_all();
      end
      if (in_ch.valid && in_ch.ready) run_command(cmd_t'(in_ch.command), in_ch.value);
      if (out_ch.valid && out_ch.ready) begin
        if (due_q.size() == 0) begin
          mismatches++;
          $display("%0t: result transaction, expected none, actual status %h data %h",
                   $time, out_ch.status, out_ch.data);
        end else begin
          r = due_q.pop_front();
          check_field("status", 32'(r.status), 32'(out_ch.status));
          check_field("data",   r.data,        out_ch.data);
          check_field("count",  32'(r.count),  32'(out_ch.count));
          check_field("last",   32'(r.last),   32'(out_ch.last));
        end
      end
    end
    results_due = due_q.size();
  end

endmodule

// File: sim/circular_ring_fifo_core_test.sv
`timescale 1ns / 100ps
// Testbench top for circular_ring_fifo_core: drives commands, capacity writes
// and result back-pressure; the checker module does prediction and comparison.
// Depends on crf_pkg, crf_if.sv, the core and circular_ring_fifo_core_checker.

module circular_ring_fifo_core_test import crf_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int          HOLD_CYCLES = 80;
  localparam int          PHASE_ITEMS = 44;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned due_count;
  int unsigned cycle_count = 0;
  bit          gaps_on;
  bit          hold_req;

  // Capacity per random phase: out-of-range codes, both ends and a few in between.
  cnt_t cap_plan [8] = '{5'd31, 5'd1, 5'd0, 5'd5, 5'd17, 5'd16, 5'd2, 5'd9};

  crf_in_if  cmd_if ();
  crf_out_if res_if ();
  crf_cfg_if cap_if ();

  circular_ring_fifo_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (cmd_if),
    .out_if (res_if),
    .cfg_if (cap_if)
  );

  circular_ring_fifo_core_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (cmd_if),
    .out_ch      (res_if),
    .cfg_ch      (cap_if),
    .mismatches  (fail_count),
    .results_due (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("circular_ring_fifo_core_test: FAIL");
      $finish;
    end
  end

  // Raw random words half of the time; the rest are the signed extremes, all ones and zero.
  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return word_t'(32'h7FFF_FFFF);
      1:       return word_t'(32'h8000_0000);
      2:       return '1;
      3:       return '0;
      default: return word_t'($urandom());
    endcase
  endfunction

  // Enqueue share in percent; the rest splits over dequeue, peek and dump.
  function automatic cmd_t pick_cmd(int enq_pct);
    if ($urandom_range(0, 99) < enq_pct) return CMD_ENQ;
    case ($urandom_range(0, 3))
      0, 1:    return CMD_DEQ;
      2:       return CMD_PEEK;
      default: return CMD_DUMP;
    endcase
  endfunction

  // Offer one command and hold it until the core takes the transaction.
  // Call at a rising edge; valid stays high across back-to-back commands.
  task automatic send_cmd(cmd_t op, word_t v);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= op;
    cmd_if.value   <= v;
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  // Stop offering and wait until every predicted result has come out.
  // Step off the edge first so the checker's count for this edge is settled.
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    @(negedge clk);
    wait (due_count == 0);
    @(posedge clk);
  endtask

  // Capacity writes happen only on an idle core: wait until every result is out
  // and let the output stage idle on briefly before the transaction.
  task automatic set_capacity(cnt_t c);
    wait_drained();
    repeat (3) @(posedge clk);
    cap_if.valid    <= 1'b1;
    cap_if.capacity <= c;
    do @(posedge clk); while (!cap_if.ready);
    cap_if.valid <= 1'b0;
  endtask

  // Result side: random ready bursts, random stall bursts while
  // gaps are on, and one long hold-off on request.
  initial begin
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 2) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    cmd_if.valid    <= 1'b0;
    cmd_if.command  <= CMD_ENQ;
    cmd_if.value    <= '0;
    cap_if.valid    <= 1'b0;
    cap_if.capacity <= '0;
    gaps_on  = 1'b1;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue at reset capacity: every non-enqueue command reports empty.
    send_cmd(CMD_DEQ,  '0);
    send_cmd(CMD_PEEK, '0);
    send_cmd(CMD_DUMP, '0);
    // Fill with the word extremes, look, dump, then drain past empty.
    send_cmd(CMD_ENQ,  word_t'(32'h7FFF_FFFF));
    send_cmd(CMD_ENQ,  word_t'(32'h8000_0000));
    send_cmd(CMD_ENQ,  '1);
    send_cmd(CMD_ENQ,  '0);
    send_cmd(CMD_PEEK, '0);
    send_cmd(CMD_DUMP, '0);
    repeat (4) send_cmd(CMD_DEQ, '0);
    send_cmd(CMD_DEQ,  '0);

    // Two slots: overflow the queue, then walk the pointers around the wrap.
    set_capacity(5'd2);
    send_cmd(CMD_ENQ,  word_t'(32'h1234_5678));
    send_cmd(CMD_ENQ,  word_t'(32'hDEAD_BEEF));
    send_cmd(CMD_ENQ,  word_t'(32'h0BAD_F00D));
    send_cmd(CMD_DUMP, '0);
    send_cmd(CMD_DEQ,  '0);
    send_cmd(CMD_ENQ,  word_t'(32'hA5A5_5A5A));
    send_cmd(CMD_DUMP, '0);
    send_cmd(CMD_DEQ,  '0);
    send_cmd(CMD_DEQ,  '0);

    // Random phases: each starts with a capacity write (which also empties the
    // queue), leans toward filling in its first half and draining in its second.
    for (int p = 0; p < 8; p++) begin
      gaps_on = (p != 7);
      set_capacity(cap_plan[p]);
      // Hold results off while the sender keeps pushing, so the output stage
      // backs up and the command channel stalls.
      if (p == 4) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 3 && i == PHASE_ITEMS / 2) wait_drained();
        send_cmd(pick_cmd(i < PHASE_ITEMS / 2 ? 70 : 30), pick_word());
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("circular_ring_fifo_core_test: PASS");
    end else begin
      $display("circular_ring_fifo_core_test: FAIL");
    end
    $finish;
  end

endmodule

// File: circular_ring_fifo_core.f
design/crf_pkg.sv
design/crf_if.sv
design/circular_ring_fifo_core.sv
sim/circular_ring_fifo_core_checker.sv
sim/circular_ring_fifo_core_test.sv
